// ----- sv/bvg_pkg.sv -----
// bvg_pkg: shared types and constants of the battery voltage gauge
// field widths, register indexes, reset values, item kinds and status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bvg_pkg;

    // field widths
    localparam int CODE_W     = 12;
    localparam int MV_W       = 16;
    localparam int CHARGE_W   = 10;
    localparam int CNT_W      = 32;
    localparam int CELLS_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // scaled voltage: average code times full scale millivolts
    localparam int PROD_W = CODE_W + MV_W;
    // threshold times full code
    localparam int THR_W  = 2 * MV_W;

    // charge quotient stays below 1024 when it is divided out
    localparam int CHARGE_QW = 10;
    localparam logic [CHARGE_W-1:0] CHARGE_FULL = 10'd1000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_V      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_V      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_V     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS      = 3'd4;

    // register reset values
    localparam logic [MV_W-1:0]    RST_FULL_SCALE = 16'd26400;
    localparam logic [MV_W-1:0]    RST_MIN_V      = 16'd13200;
    localparam logic [MV_W-1:0]    RST_MAX_V      = 16'd16800;
    localparam logic [MV_W-1:0]    RST_CRIT_V     = 16'd12800;
    localparam logic [CELLS_W-1:0] RST_CELLS      = 4'd4;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic [MV_W-1:0]    full_scale_mv;
        logic [MV_W-1:0]    min_voltage_mv;
        logic [MV_W-1:0]    max_voltage_mv;
        logic [MV_W-1:0]    critical_voltage_mv;
        logic [CELLS_W-1:0] cells_in_series;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- sv/bvg_if.sv -----
// bvg_in_if and bvg_out_if: valid/ready channels of the battery voltage gauge
// depends on bvg_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bvg_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [bvg_pkg::CODE_W-1:0] sample_code;
    logic                       sample_ok;

    modport source (output valid, kind, sample_code, sample_ok, input ready);
    modport sink   (input valid, kind, sample_code, sample_ok, output ready);
endinterface

interface bvg_out_if;
    logic                         valid;
    logic                         ready;
    logic [bvg_pkg::CODE_W-1:0]   average_code;
    logic [bvg_pkg::MV_W-1:0]     battery_mv;
    logic [bvg_pkg::CHARGE_W-1:0] charge_tenths;
    logic [bvg_pkg::MV_W-1:0]     cell_mv;
    logic                         level_ok;
    logic                         level_low;
    logic                         level_critical;
    logic [bvg_pkg::CNT_W-1:0]    checks_done;
    logic [bvg_pkg::CNT_W-1:0]    critical_events;

    modport source (output valid, average_code, battery_mv, charge_tenths, cell_mv,
                    level_ok, level_low, level_critical, checks_done, critical_events,
                    input ready);
    modport sink   (input valid, average_code, battery_mv, charge_tenths, cell_mv,
                    level_ok, level_low, level_critical, checks_done, critical_events,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/bvg_div.sv -----
// bvg_div: shared restoring divider, one quotient bit per cycle
// caller supplies a starting remainder below the divisor; no package use
`timescale 1ns / 1ps
`default_nettype none

module bvg_div #(
    parameter int NUMW = 28,
    parameter int DENW = 32,
    parameter int CNTW = 5
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [DENW-1:0] rem_init,
    input  wire logic [NUMW-1:0] num,
    input  wire logic [DENW-1:0] den,
    input  wire logic [CNTW-1:0] steps,
    output logic                 done,
    output logic [NUMW-1:0]      quot
);

    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [DENW-1:0] rem_reg;
    logic [DENW-1:0] den_reg;
    logic [NUMW-1:0] num_reg;
    logic [NUMW-1:0] quot_reg;

    logic            busy;
    logic [DENW:0]   trial;
    logic            fits;
    logic [DENW:0]   diff;

    // one compare and subtract per step
    assign busy  = (cnt_reg != '0);
    assign trial = {rem_reg, num_reg[NUMW-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy && (cnt_reg == CNTW'(1));
            if (start)
                cnt_reg <= steps;
            else if (busy)
                cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    // remainder, dividend and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            den_reg  <= den;
            num_reg  <= num;
            quot_reg <= '0;
        end
        else if (busy)
        begin
            rem_reg  <= fits ? diff[DENW-1:0] : trial[DENW-1:0];
            num_reg  <= num_reg << 1;
            quot_reg <= {quot_reg[NUMW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- sv/bvg_queue.sv -----
// bvg_queue: short fifo of work entries between front and back
// depends on bvg_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module bvg_queue #(
    parameter int W     = 17,
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [W-1:0]       push_data,
    input  wire logic               pop,
    output logic [W-1:0]            head,
    output bvg_pkg::q_status_t      stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    // pointer and fill tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- sv/bvg_front.sv -----
// bvg_front: accepts input items, sums each group of samples, queues work
// depends on bvg_pkg and bvg_in_if
`timescale 1ns / 1ps
`default_nettype none

module bvg_front #(
    parameter int SAMPLES = 16,
    parameter int SUMW    = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bvg_in_if.sink             in_ch,
    input  bvg_pkg::q_status_t q_stat,
    output logic               push,
    output logic [SUMW:0]      push_data
);

    localparam int IDXW = $clog2(SAMPLES);

    logic [IDXW-1:0] idx_reg;
    logic [SUMW-1:0] sum_reg;

    logic            accept;
    logic            is_clear;
    logic            group_end;
    logic [SUMW-1:0] sum_add;

    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_clear    = (in_ch.kind == bvg_pkg::KIND_CLEAR);
    assign group_end   = (idx_reg == IDXW'(SAMPLES - 1));

    // failed reads add zero
    assign sum_add = sum_reg + (in_ch.sample_ok ? SUMW'(in_ch.sample_code) : '0);

    // a clear or a finished group goes to the back
    assign push      = accept && (is_clear || group_end);
    assign push_data = is_clear ? {bvg_pkg::KIND_CLEAR, SUMW'(0)}
                                : {bvg_pkg::KIND_SAMPLE, sum_add};

    // group accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (accept && !is_clear)
        begin
            if (group_end)
            begin
                idx_reg <= '0;
                sum_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + IDXW'(1);
                sum_reg <= sum_add;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/bvg_back.sv -----
// bvg_back: sequencer that turns a group sum into a voltage check result
// depends on bvg_pkg, bvg_out_if and bvg_div
`timescale 1ns / 1ps
`default_nettype none

module bvg_back #(
    parameter int SAMPLES   = 16,
    parameter int FULL_CODE = 4095,
    parameter int SUMW      = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  bvg_pkg::cfg_t      cfg,
    input  bvg_pkg::q_status_t q_stat,
    input  wire logic [SUMW:0] head,
    output logic               pop,
    bvg_out_if.source          out_ch
);

    localparam int PROD_W = bvg_pkg::PROD_W;
    localparam int THR_W  = bvg_pkg::THR_W;
    localparam int MV_W   = bvg_pkg::MV_W;
    localparam int CODE_W = bvg_pkg::CODE_W;
    localparam int CNT_W  = bvg_pkg::CNT_W;
    localparam int CQW    = bvg_pkg::CHARGE_QW;
    localparam int CHW    = bvg_pkg::CHARGE_W;
    localparam int SCW    = THR_W + CQW;
    localparam int NUMW   = MV_W;
    localparam int DENW   = THR_W;
    localparam int CNTW   = $clog2(NUMW + 1);

    // reciprocal of the sample count, exact for every group sum
    localparam int AVG_L  = $clog2(SAMPLES);
    localparam int AVG_S  = SUMW + AVG_L;
    localparam int AVG_MW = SUMW + 1;
    localparam int AVG_PW = SUMW + AVG_MW;
    localparam logic [63:0] AVG_M =
        ((64'd1 << AVG_S) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);

    // reciprocal of the full code, exact for every scaled voltage
    localparam int MV_L  = $clog2(FULL_CODE);
    localparam int MV_S  = PROD_W + MV_L;
    localparam int MV_MW = PROD_W + 1;
    localparam int MV_PW = PROD_W + MV_MW;
    localparam logic [63:0] MV_M =
        ((64'd1 << MV_S) + 64'(FULL_CODE) - 64'd1) / 64'(FULL_CODE);

    localparam logic [MV_W-1:0] FULL_C = MV_W'(FULL_CODE);

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_PROD = 4'd2;
    localparam logic [3:0] ST_MUL_MIN  = 4'd3;
    localparam logic [3:0] ST_MUL_MAX  = 4'd4;
    localparam logic [3:0] ST_MUL_CRIT = 4'd5;
    localparam logic [3:0] ST_EVAL     = 4'd6;
    localparam logic [3:0] ST_MV       = 4'd7;
    localparam logic [3:0] ST_CELL     = 4'd8;
    localparam logic [3:0] ST_CHG      = 4'd9;
    localparam logic [3:0] ST_OUT      = 4'd10;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;

    logic [CODE_W-1:0] avg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [THR_W-1:0]  min_s_reg;
    logic [THR_W-1:0]  max_s_reg;
    logic [THR_W-1:0]  crit_s_reg;
    logic              low_reg;
    logic              crit_reg;
    logic              good_reg;
    logic              need_div_reg;
    logic [THR_W-1:0]  diff_reg;
    logic [THR_W-1:0]  span_reg;
    logic [SCW-1:0]    scaled_reg;
    logic [MV_W-1:0]   mv_reg;
    logic [MV_W-1:0]   cell_reg;
    logic [CHW-1:0]    charge_reg;
    logic [CNT_W-1:0]  chk_cnt_reg;
    logic [CNT_W-1:0]  crit_cnt_reg;
    logic              out_valid_reg;

    logic              div_start;
    logic [DENW-1:0]   div_rem_init;
    logic [NUMW-1:0]   div_num;
    logic [DENW-1:0]   div_den;
    logic [CNTW-1:0]   div_steps;
    logic              div_done;
    logic [NUMW-1:0]   div_quot;

    logic [MV_W-1:0]   mul_a;
    logic [MV_W-1:0]   mul_b;
    logic [THR_W-1:0]  mul_p;
    logic [THR_W-1:0]  prod_ext;
    logic [AVG_PW-1:0] avg_prod;
    logic [CODE_W-1:0] avg_calc;
    logic [MV_PW-1:0]  mv_prod;
    logic [PROD_W-1:0] mv_q;
    logic [MV_W-1:0]   mv_sat;
    logic [DENW-1:0]   cells_den;
    logic              load_out;
    logic              clear_cnt;
    logic              head_clear;
    logic [SUMW-1:0]   head_sum;

    assign head_clear = (head[SUMW] == bvg_pkg::KIND_CLEAR);
    assign head_sum   = head[SUMW-1:0];
    assign prod_ext   = THR_W'(prod_reg);

    // group average by reciprocal multiplication
    assign avg_prod = AVG_PW'(head_sum) * AVG_PW'(AVG_M[AVG_MW-1:0]);
    assign avg_calc = CODE_W'(avg_prod >> AVG_S);

    // voltage quotient by reciprocal multiplication, saturated at the field width
    assign mv_prod = MV_PW'(prod_reg) * MV_PW'(MV_M[MV_MW-1:0]);
    assign mv_q    = PROD_W'(mv_prod >> MV_S);
    assign mv_sat  = (|mv_q[PROD_W-1:MV_W]) ? {MV_W{1'b1}} : mv_q[MV_W-1:0];
    // zero cells counts as one
    assign cells_den = (cfg.cells_in_series == '0) ? DENW'(1) : DENW'(cfg.cells_in_series);

    bvg_div #(
        .NUMW (NUMW),
        .DENW (DENW),
        .CNTW (CNTW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .num      (div_num),
        .den      (div_den),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (div_quot)
    );

    // shared multiplier, operands chosen by state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_PROD:
            begin
                mul_a = MV_W'(avg_reg);
                mul_b = cfg.full_scale_mv;
            end
            ST_MUL_MIN:
            begin
                mul_a = FULL_C;
                mul_b = cfg.min_voltage_mv;
            end
            ST_MUL_MAX:
            begin
                mul_a = FULL_C;
                mul_b = cfg.max_voltage_mv;
            end
            ST_MUL_CRIT:
            begin
                mul_a = FULL_C;
                mul_b = cfg.critical_voltage_mv;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = THR_W'(mul_a) * THR_W'(mul_b);

    // sequencer control and divider requests
    always_comb
    begin
        state_next   = state_reg;
        pop          = 1'b0;
        clear_cnt    = 1'b0;
        load_out     = 1'b0;
        div_start    = 1'b0;
        div_rem_init = '0;
        div_num      = '0;
        div_den      = '0;
        div_steps    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    if (head_clear)
                        clear_cnt = 1'b1;
                    else
                        state_next = ST_MUL_PROD;
                end
            end
            ST_MUL_PROD: state_next = ST_MUL_MIN;
            ST_MUL_MIN:  state_next = ST_MUL_MAX;
            ST_MUL_MAX:  state_next = ST_MUL_CRIT;
            ST_MUL_CRIT: state_next = ST_EVAL;
            ST_EVAL:     state_next = ST_MV;
            ST_MV:
            begin
                div_start  = 1'b1;
                div_num    = NUMW'(mv_reg);
                div_den    = cells_den;
                div_steps  = CNTW'(MV_W);
                state_next = ST_CELL;
            end
            ST_CELL:
            begin
                if (div_done)
                begin
                    if (need_div_reg)
                    begin
                        div_start    = 1'b1;
                        div_rem_init = scaled_reg[SCW-1:CQW];
                        div_num      = NUMW'(scaled_reg[CQW-1:0]) << (NUMW - CQW);
                        div_den      = span_reg;
                        div_steps    = CNTW'(CQW);
                        state_next   = ST_CHG;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_CHG:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_cnt_reg   <= '0;
            crit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_cnt)
            begin
                chk_cnt_reg  <= '0;
                crit_cnt_reg <= '0;
            end
            else if (load_out)
            begin
                chk_cnt_reg  <= chk_cnt_reg + CNT_W'(1);
                crit_cnt_reg <= crit_cnt_reg + CNT_W'(crit_reg);
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty && !head_clear)
                    avg_reg <= avg_calc;
            end
            ST_MUL_PROD: prod_reg   <= mul_p[PROD_W-1:0];
            ST_MUL_MIN:  min_s_reg  <= mul_p;
            ST_MUL_MAX:  max_s_reg  <= mul_p;
            ST_MUL_CRIT: crit_s_reg <= mul_p;
            ST_EVAL:
            begin
                // thresholds compared on the exact scaled voltage
                low_reg      <= (prod_ext <= min_s_reg);
                crit_reg     <= (prod_ext <= crit_s_reg);
                good_reg     <= (prod_ext > min_s_reg) && (prod_ext <= max_s_reg);
                need_div_reg <= (prod_ext > min_s_reg) && (prod_ext < max_s_reg);
                diff_reg     <= prod_ext - min_s_reg;
                span_reg     <= max_s_reg - min_s_reg;
                mv_reg       <= mv_sat;
            end
            ST_MV:
            begin
                scaled_reg <= SCW'(diff_reg) * SCW'(bvg_pkg::CHARGE_FULL);
            end
            ST_CELL:
            begin
                if (div_done)
                begin
                    cell_reg <= div_quot[MV_W-1:0];
                    if (!need_div_reg)
                        charge_reg <= low_reg ? '0 : bvg_pkg::CHARGE_FULL;
                end
            end
            ST_CHG:
            begin
                if (div_done)
                    charge_reg <= div_quot[CHW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ch.average_code    <= avg_reg;
            out_ch.battery_mv      <= mv_reg;
            out_ch.charge_tenths   <= charge_reg;
            out_ch.cell_mv         <= cell_reg;
            out_ch.level_ok        <= good_reg;
            out_ch.level_low       <= low_reg;
            out_ch.level_critical  <= crit_reg;
            out_ch.checks_done     <= chk_cnt_reg + CNT_W'(1);
            out_ch.critical_events <= crit_cnt_reg + CNT_W'(crit_reg);
        end
    end

    assign out_ch.valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- sv/battery_voltage_gauge_unit.sv -----
// battery_voltage_gauge_unit: top level, configuration registers and wiring
// depends on bvg_pkg, bvg_if, bvg_front, bvg_queue, bvg_back
`timescale 1ns / 1ps
`default_nettype none

// Battery voltage gauge. Input items are accepted one per cycle while the
// four-entry work queue has room; every SAMPLES_PER_CHECK samples the front
// queues the group sum, and a clear item is queued in order with the checks.
// The back divides by the constant sample count and full code through
// reciprocal multiplications, and uses one shared radix-2 divider (one
// quotient bit per cycle) for the cell count and the charge span, plus one
// shared 16x16 multiplier. A check in the back runs the multiply and evaluate
// states, the 16-step cell division, the 10-step charge division and the
// output state before the next queued item is taken; the charge division is
// skipped when max and min leave the voltage at or outside the charge span. A
// clear only resets the counters. A result waits in the output register while
// the receiver holds off. Registers are written through cfg_we/cfg_index/
// cfg_wdata, by the user only while the block is idle; the block does not check.
module battery_voltage_gauge_unit #(
    parameter int SAMPLES_PER_CHECK = 16,
    parameter int ADC_FULL_CODE     = 4095
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    bvg_in_if.sink                                in_ch,
    bvg_out_if.source                             out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [bvg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bvg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int SUMW = $clog2(SAMPLES_PER_CHECK * ((1 << bvg_pkg::CODE_W) - 1) + 1);

    bvg_pkg::cfg_t      cfg_reg;
    bvg_pkg::q_status_t q_stat;
    logic               push;
    logic [SUMW:0]      push_data;
    logic               pop;
    logic [SUMW:0]      head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale_mv       <= bvg_pkg::RST_FULL_SCALE;
            cfg_reg.min_voltage_mv      <= bvg_pkg::RST_MIN_V;
            cfg_reg.max_voltage_mv      <= bvg_pkg::RST_MAX_V;
            cfg_reg.critical_voltage_mv <= bvg_pkg::RST_CRIT_V;
            cfg_reg.cells_in_series     <= bvg_pkg::RST_CELLS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bvg_pkg::REG_FULL_SCALE: cfg_reg.full_scale_mv       <= cfg_wdata;
                bvg_pkg::REG_MIN_V:      cfg_reg.min_voltage_mv      <= cfg_wdata;
                bvg_pkg::REG_MAX_V:      cfg_reg.max_voltage_mv      <= cfg_wdata;
                bvg_pkg::REG_CRIT_V:     cfg_reg.critical_voltage_mv <= cfg_wdata;
                bvg_pkg::REG_CELLS:
                    cfg_reg.cells_in_series <= cfg_wdata[bvg_pkg::CELLS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    bvg_front #(
        .SAMPLES (SAMPLES_PER_CHECK),
        .SUMW    (SUMW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    bvg_queue #(
        .W     (SUMW + 1),
        .DEPTH (bvg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    bvg_back #(
        .SAMPLES   (SAMPLES_PER_CHECK),
        .FULL_CODE (ADC_FULL_CODE),
        .SUMW      (SUMW)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // no push into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("work queue pushed while full");

    // no pop from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("work queue popped while empty");

    // a push without a pop leaves the queue non-empty in the next cycle
    a_push_makes_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> !q_stat.empty)
        else $error("queue empty after a push");

    // ok and low flags exclude each other
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.level_ok && out_ch.level_low))
        else $error("level ok and low both set");

endmodule

`default_nettype wire
